// ===== src/bfv_pkg.sv =====
package bfv_pkg;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         uav_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               enable_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] cmd_z;
        logic               cmd_enabled;
    } t_out_word;

    // one neighbour table row, element 0 is x
    typedef struct packed {
        logic [7:0]       id;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        F_OWN_POS  = 3'd0,
        F_NEIGHBOR = 3'd1,
        F_TARGET   = 3'd2,
        F_OFFSET   = 3'd3,
        F_ENABLE   = 3'd4,
        F_TICK     = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        R_GAIN_COH = 3'd0,
        R_GAIN_SEP = 3'd1,
        R_GAIN_ALI = 3'd2,
        R_GAIN_MIG = 3'd3,
        R_SPEED    = 3'd4,
        R_VISION   = 3'd5,
        R_OWN_ID   = 3'd6
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_T_RD,
        S_T_LD,
        S_SQ,
        S_SQRT,
        S_SEP_CHK,
        S_SEP_MUL,
        S_SEP_ACC,
        S_AVG_SET,
        S_AVG_ACC,
        S_MIG,
        S_MAC,
        S_FLOOR,
        S_SHIFT,
        S_NSQ,
        S_CL_CHK,
        S_CL_MUL,
        S_CL_ACC,
        S_DIV,
        S_OUT
    } t_state;

    localparam logic [1:0] V_COH = 2'd0;
    localparam logic [1:0] V_SEP = 2'd1;
    localparam logic [1:0] V_ALI = 2'd2;
    localparam logic [1:0] V_MIG = 2'd3;

    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam logic [30:0] SPEED_RESET  = 31'd65536;
    localparam logic [30:0] VISION_RESET = 31'd327680;
    localparam logic [31:0] SEP_MIN_DIST = 32'd655;
    localparam logic [31:0] SEP_SUB_DIST = 32'd6554;
    localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

endpackage

// ===== src/boids_flocking_velocity.sv =====
// flocking velocity controller, signed Q16.16
// input channel i_in_valid / o_in_stall carries one word: own position, neighbour
// odometry, migration target, formation offset, enable or tick, selected by func.
// output channel o_out_valid / i_out_stall carries one command word per tick.
// gains, speed limit, vision range and own id sit behind the apb port; the user
// must write them only while the block is idle, the block does not enforce it; pready is always high.
// position, target, offset and enable words are taken in the idle state. a neighbour
// word searches the table row by row, with a read step and a check step per row.
// a tick walks the table through one 32x32 multiplier, a 64-step divider and a
// 32-step square root; with an empty table it goes straight to the output step.
// the block takes no word while it is busy; a finished command waits in the
// output register, so the next word is taken while the receiver stalls, and a
// second tick holds in its last step until that register is free.
// reset (synchronous, active low) empties the table, clears position, target,
// offset and enable and loads the register defaults; no clearing pass is needed.
module boids_flocking_velocity
    import bfv_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);

    t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx;
    logic [1:0] r_j, n_j, r_k, n_k;
    logic r_h, n_h;
    t_in_word r_item, n_item;
    logic signed [31:0] r_own [3], n_own [3];
    logic signed [31:0] r_tgt [3], n_tgt [3];
    logic signed [31:0] r_form [3], n_form [3];
    logic signed [31:0] r_lead [3], n_lead [3];
    logic r_enabled, n_enabled;

    logic signed [15:0] r_gc, r_gs, r_ga, r_gm;
    logic [30:0] r_speed, r_vision;
    logic [7:0] r_own_id;

    logic signed [63:0] r_coh [3], n_coh [3];
    logic signed [63:0] r_sep [3], n_sep [3];
    logic signed [63:0] r_ali [3], n_ali [3];
    logic signed [63:0] r_mig [3], n_mig [3];
    logic signed [63:0] r_res [3], n_res [3];
    logic [31:0] r_dfm [3], n_dfm [3];
    logic r_dfn [3], n_dfn [3];
    logic [63:0] r_m [3], n_m [3];
    logic r_rneg [3], n_rneg [3];
    logic r_shft, n_shft;

    logic [63:0] r_sq, n_sq, r_sx, n_sx, r_sr, n_sr, r_sbit, n_sbit;
    logic [31:0] r_d, n_d, r_difm, n_difm;
    logic r_difn, n_difn;
    logic [63:0] r_dq, n_dq;
    logic [31:0] r_drem, n_drem, r_ddiv, n_ddiv;
    logic [5:0] r_dcnt, n_dcnt;
    logic r_dneg, n_dneg;

    logic r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic ram_we;
    t_entry ent, wr_ent;
    logic [ENTRY_W-1:0] ram_rdata;
    logic signed [63:0] vsel;
    logic signed [15:0] gsel;
    logic [63:0] vmag;
    logic [16:0] gmag;
    logic cfg_we;

    bfv_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NEIGHBORS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent = t_entry'(ram_rdata);

    always_comb begin
        wr_ent.id     = r_item.uav_id;
        wr_ent.pos[0] = r_item.pos_x;
        wr_ent.pos[1] = r_item.pos_y;
        wr_ent.pos[2] = r_item.pos_z;
        wr_ent.vel[0] = r_item.vel_x;
        wr_ent.vel[1] = r_item.vel_y;
        wr_ent.vel[2] = r_item.vel_z;
    end

    // vector and gain picked by the term counters
    always_comb begin
        case (r_j)
            V_COH:   vsel = r_coh[r_k];
            V_SEP:   vsel = r_sep[r_k];
            V_ALI:   vsel = r_ali[r_k];
            default: vsel = r_mig[r_k];
        endcase
        case (r_j)
            V_COH:   gsel = r_gc;
            V_SEP:   gsel = r_gs;
            V_ALI:   gsel = r_ga;
            default: gsel = r_gm;
        endcase
        vmag = vsel[63] ? 64'(-vsel) : 64'(vsel);
        gmag = gsel[15] ? 17'(-$signed({gsel[15], gsel})) : {1'b0, gsel};
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = r_dfm[r_k];
                mul_b = r_dfm[r_k];
            end
            S_SEP_MUL: begin
                mul_a = r_dfm[r_k];
                mul_b = r_difm;
            end
            S_MAC: begin
                mul_a = r_h ? vmag[63:32] : vmag[31:0];
                mul_b = {15'b0, gmag};
            end
            S_NSQ: begin
                mul_a = r_m[r_k][31:0];
                mul_b = r_m[r_k][31:0];
            end
            S_CL_MUL: begin
                mul_a = r_m[r_k][31:0];
                mul_b = {1'b0, r_speed};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        logic signed [32:0] df [3];
        logic [32:0] dfmag [3];
        logic near;
        logic [63:0] ssum;
        logic [32:0] dtmp;
        logic dbit;
        logic [31:0] dd;
        logic signed [32:0] dif;
        logic signed [63:0] q;
        logic [63:0] part;
        logic signed [63:0] f;

        n_state = r_state;
        n_ret = r_ret;
        n_count = r_count;
        n_idx = r_idx;
        n_j = r_j;
        n_k = r_k;
        n_h = r_h;
        n_item = r_item;
        n_own = r_own;
        n_tgt = r_tgt;
        n_form = r_form;
        n_lead = r_lead;
        n_enabled = r_enabled;
        n_coh = r_coh;
        n_sep = r_sep;
        n_ali = r_ali;
        n_mig = r_mig;
        n_res = r_res;
        n_dfm = r_dfm;
        n_dfn = r_dfn;
        n_m = r_m;
        n_rneg = r_rneg;
        n_shft = r_shft;
        n_sq = r_sq;
        n_sx = r_sx;
        n_sr = r_sr;
        n_sbit = r_sbit;
        n_d = r_d;
        n_difm = r_difm;
        n_difn = r_difn;
        n_dq = r_dq;
        n_drem = r_drem;
        n_ddiv = r_ddiv;
        n_dcnt = r_dcnt;
        n_dneg = r_dneg;
        n_out_word = r_out_word;
        n_out_valid = r_out_valid & i_out_stall;
        ram_we = 1'b0;
        near = 1'b1;
        ssum = r_sq + mul_p;
        q = r_dneg ? -$signed(r_dq) : $signed(r_dq);
        part = r_h ? {mul_p[31:0], 32'b0} : mul_p;
        dtmp = {r_drem, r_dq[63]};
        dbit = (dtmp >= {1'b0, r_ddiv});
        dd = r_sr[31:0];
        dif = '0;
        f = '0;
        for (int kk = 0; kk < 3; kk++) begin
            df[kk] = 33'(r_own[kk]) - 33'($signed(ent.pos[kk]));
            dfmag[kk] = df[kk][32] ? 33'(-df[kk]) : 33'(df[kk]);
            if (dfmag[kk] >= {2'b0, r_vision}) begin
                near = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_word;
                    case (t_func'(i_in_word.func))
                        F_OWN_POS: begin
                            n_own[0] = i_in_word.pos_x;
                            n_own[1] = i_in_word.pos_y;
                            n_own[2] = i_in_word.pos_z;
                        end
                        F_NEIGHBOR: begin
                            if (i_in_word.uav_id != r_own_id) begin
                                n_idx = '0;
                                n_state = S_FIND_RD;
                            end
                        end
                        F_TARGET: begin
                            n_tgt[0] = i_in_word.pos_x;
                            n_tgt[1] = i_in_word.pos_y;
                            n_tgt[2] = i_in_word.pos_z;
                        end
                        F_OFFSET: begin
                            n_form[0] = i_in_word.pos_x;
                            n_form[1] = i_in_word.pos_y;
                            n_form[2] = i_in_word.pos_z;
                        end
                        F_ENABLE: begin
                            n_enabled = i_in_word.enable_value;
                        end
                        F_TICK: begin
                            for (int kk = 0; kk < 3; kk++) begin
                                n_coh[kk] = '0;
                                n_sep[kk] = '0;
                                n_ali[kk] = '0;
                                n_lead[kk] = '0;
                                n_res[kk] = '0;
                            end
                            n_idx = '0;
                            n_state = (r_count == '0) ? S_OUT : S_T_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_idx == r_count) begin
                    if (r_count < CW'(MAX_NEIGHBORS)) begin
                        ram_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (ent.id == r_item.uav_id) begin
                    ram_we = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_T_RD: begin
                if (r_idx == r_count) begin
                    n_j = V_COH;
                    n_k = '0;
                    n_state = S_AVG_SET;
                end else begin
                    n_state = S_T_LD;
                end
            end
            S_T_LD: begin
                n_idx = r_idx + 1'b1;
                n_state = S_T_RD;
                if (ent.id == 8'd0) begin
                    for (int kk = 0; kk < 3; kk++) begin
                        n_lead[kk] = $signed(ent.pos[kk]);
                    end
                end
                if (ent.id != r_own_id) begin
                    for (int kk = 0; kk < 3; kk++) begin
                        n_coh[kk] = r_coh[kk] + 64'($signed(ent.pos[kk]));
                        n_ali[kk] = r_ali[kk] + 64'($signed(ent.vel[kk]));
                        n_dfm[kk] = dfmag[kk][31:0];
                        n_dfn[kk] = df[kk][32];
                    end
                    if (near) begin
                        n_idx = r_idx;
                        n_sq = '0;
                        n_k = '0;
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                n_sq = ssum;
                n_k = r_k + 1'b1;
                if (r_k == 2'd2) begin
                    n_sx = ssum;
                    n_sr = '0;
                    n_sbit = SQRT_TOP_BIT;
                    n_ret = S_SEP_CHK;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_sx >= r_sr + r_sbit) begin
                    n_sx = r_sx - (r_sr + r_sbit);
                    n_sr = (r_sr >> 1) + r_sbit;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_sbit = r_sbit >> 2;
                if (r_sbit[0]) begin
                    n_state = r_ret;
                end
            end
            S_SEP_CHK: begin
                if (dd < {1'b0, r_vision}) begin
                    if (dd < SEP_MIN_DIST) begin
                        dd = SEP_SUB_DIST;
                    end
                    dif = $signed({2'b0, r_vision}) - $signed({1'b0, dd});
                    n_d = dd;
                    n_difn = dif[32];
                    n_difm = dif[32] ? 32'(-dif) : dif[31:0];
                    n_k = '0;
                    n_state = S_SEP_MUL;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_T_RD;
                end
            end
            S_SEP_MUL: begin
                n_dq = mul_p;
                n_drem = '0;
                n_ddiv = r_d;
                n_dcnt = '0;
                n_dneg = r_dfn[r_k] ^ r_difn;
                n_ret = S_SEP_ACC;
                n_state = S_DIV;
            end
            S_SEP_ACC: begin
                n_sep[r_k] = r_sep[r_k] + q;
                n_k = r_k + 1'b1;
                if (r_k == 2'd2) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_T_RD;
                end else begin
                    n_state = S_SEP_MUL;
                end
            end
            S_AVG_SET: begin
                n_dq = vmag;
                n_drem = '0;
                n_ddiv = 32'(r_count);
                n_dcnt = '0;
                n_dneg = vsel[63];
                n_ret = S_AVG_ACC;
                n_state = S_DIV;
            end
            S_AVG_ACC: begin
                if (r_j == V_COH) begin
                    n_coh[r_k] = q - 64'(r_own[r_k]);
                end else begin
                    n_ali[r_k] = q;
                end
                n_k = r_k + 1'b1;
                n_state = S_AVG_SET;
                if (r_k == 2'd2) begin
                    n_k = '0;
                    if (r_j == V_COH) begin
                        n_j = V_ALI;
                    end else begin
                        n_state = S_MIG;
                    end
                end
            end
            S_MIG: begin
                for (int kk = 0; kk < 3; kk++) begin
                    n_mig[kk] = 64'(r_form[kk]) - 64'(r_own[kk])
                              + ((r_own_id != 8'd0) ? 64'(r_lead[kk]) : 64'(r_tgt[kk]));
                    n_res[kk] = '0;
                end
                n_j = V_COH;
                n_k = '0;
                n_h = 1'b0;
                n_state = S_MAC;
            end
            S_MAC: begin
                if (vsel[63] ^ gsel[15]) begin
                    n_res[r_k] = r_res[r_k] - $signed(part);
                end else begin
                    n_res[r_k] = r_res[r_k] + $signed(part);
                end
                n_h = ~r_h;
                if (r_h) begin
                    n_k = (r_k == 2'd2) ? 2'd0 : r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        n_j = r_j + 1'b1;
                        if (r_j == V_MIG) begin
                            n_state = S_FLOOR;
                        end
                    end
                end
            end
            S_FLOOR: begin
                for (int kk = 0; kk < 3; kk++) begin
                    f = r_res[kk] >>> 8;
                    n_res[kk] = f;
                    n_m[kk] = f[63] ? 64'(-f) : 64'(f);
                    n_rneg[kk] = f[63];
                end
                n_shft = 1'b0;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_m[0][63:31] == '0 && r_m[1][63:31] == '0 && r_m[2][63:31] == '0) begin
                    n_sq = '0;
                    n_k = '0;
                    n_state = S_NSQ;
                end else begin
                    for (int kk = 0; kk < 3; kk++) begin
                        n_m[kk] = r_m[kk] >> 1;
                    end
                    n_shft = 1'b1;
                end
            end
            S_NSQ: begin
                n_sq = ssum;
                n_k = r_k + 1'b1;
                if (r_k == 2'd2) begin
                    n_sx = ssum;
                    n_sr = '0;
                    n_sbit = SQRT_TOP_BIT;
                    n_ret = S_CL_CHK;
                    n_state = S_SQRT;
                end
            end
            S_CL_CHK: begin
                n_state = S_OUT;
                if (r_shft || dd >= {1'b0, r_speed}) begin
                    if (dd == '0) begin
                        for (int kk = 0; kk < 3; kk++) begin
                            n_res[kk] = '0;
                        end
                    end else begin
                        n_d = dd;
                        n_k = '0;
                        n_state = S_CL_MUL;
                    end
                end
            end
            S_CL_MUL: begin
                n_dq = mul_p;
                n_drem = '0;
                n_ddiv = r_d;
                n_dcnt = '0;
                n_dneg = r_rneg[r_k];
                n_ret = S_CL_ACC;
                n_state = S_DIV;
            end
            S_CL_ACC: begin
                n_res[r_k] = q;
                n_k = r_k + 1'b1;
                n_state = (r_k == 2'd2) ? S_OUT : S_CL_MUL;
            end
            S_DIV: begin
                n_drem = dbit ? 32'(dtmp - {1'b0, r_ddiv}) : dtmp[31:0];
                n_dq = {r_dq[62:0], dbit};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 6'd63) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_word.cmd_x = r_res[0][31:0];
                    n_out_word.cmd_y = r_res[1][31:0];
                    n_out_word.cmd_z = r_res[2][31:0];
                    n_out_word.cmd_enabled = r_enabled;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_enabled <= 1'b0;
            r_out_valid <= 1'b0;
            for (int kk = 0; kk < 3; kk++) begin
                r_own[kk] <= '0;
                r_tgt[kk] <= '0;
                r_form[kk] <= '0;
            end
            r_gc <= GAIN_RESET;
            r_gs <= GAIN_RESET;
            r_ga <= GAIN_RESET;
            r_gm <= GAIN_RESET;
            r_speed <= SPEED_RESET;
            r_vision <= VISION_RESET;
            r_own_id <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_enabled <= n_enabled;
            r_out_valid <= n_out_valid;
            r_own <= n_own;
            r_tgt <= n_tgt;
            r_form <= n_form;
            if (cfg_we) begin
                unique case (t_reg'(paddr[4:2]))
                    R_GAIN_COH: r_gc <= pwdata[15:0];
                    R_GAIN_SEP: r_gs <= pwdata[15:0];
                    R_GAIN_ALI: r_ga <= pwdata[15:0];
                    R_GAIN_MIG: r_gm <= pwdata[15:0];
                    R_SPEED:    r_speed <= pwdata[30:0];
                    R_VISION:   r_vision <= pwdata[30:0];
                    R_OWN_ID:   r_own_id <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_idx <= n_idx;
        r_j <= n_j;
        r_k <= n_k;
        r_h <= n_h;
        r_item <= n_item;
        r_lead <= n_lead;
        r_coh <= n_coh;
        r_sep <= n_sep;
        r_ali <= n_ali;
        r_mig <= n_mig;
        r_res <= n_res;
        r_dfm <= n_dfm;
        r_dfn <= n_dfn;
        r_m <= n_m;
        r_rneg <= n_rneg;
        r_shft <= n_shft;
        r_sq <= n_sq;
        r_sx <= n_sx;
        r_sr <= n_sr;
        r_sbit <= n_sbit;
        r_d <= n_d;
        r_difm <= n_difm;
        r_difn <= n_difn;
        r_dq <= n_dq;
        r_drem <= n_drem;
        r_ddiv <= n_ddiv;
        r_dcnt <= n_dcnt;
        r_dneg <= n_dneg;
        r_out_word <= n_out_word;
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            R_GAIN_COH: prdata = {16'b0, r_gc};
            R_GAIN_SEP: prdata = {16'b0, r_gs};
            R_GAIN_ALI: prdata = {16'b0, r_ga};
            R_GAIN_MIG: prdata = {16'b0, r_gm};
            R_SPEED:    prdata = {1'b0, r_speed};
            R_VISION:   prdata = {1'b0, r_vision};
            R_OWN_ID:   prdata = {24'b0, r_own_id};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NEIGHBORS))
        else $error("neighbour count beyond table size");

    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("command word raised outside the output step");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_ddiv != '0)
        else $error("divider started with zero divisor");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.func == F_TICK) |=> r_state != S_IDLE)
        else $error("tick word did not start work");

    a_count_grows_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> r_count == $past(r_count) + 1'b1)
        else $error("neighbour count moved by more than one");

endmodule

// ===== src/bfv_ram.sv =====
module bfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/boids_flocking_velocity_tb.sv =====
`timescale 1ns / 100ps

module boids_flocking_velocity_tb;
    import bfv_pkg::*;

    localparam int NB_MAX      = 16;
    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    boids_flocking_velocity #(.MAX_NEIGHBORS(NB_MAX)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow state of the controller
    longint             g_coh = 256, g_sep = 256, g_ali = 256, g_mig = 256;
    longint             spd_lim = 65536, vis_rng = 327680;
    logic [7:0]         self_id = '0;
    logic [7:0]         nb_id [NB_MAX];
    logic signed [31:0] nb_pos [NB_MAX][3];
    logic signed [31:0] nb_vel [NB_MAX][3];
    int                 nb_cnt = 0;
    logic signed [31:0] own_pos [3] = '{0, 0, 0};
    logic signed [31:0] tgt_pos [3] = '{0, 0, 0};
    logic signed [31:0] frm_off [3] = '{0, 0, 0};
    logic               ctl_en = 1'b0;

    t_in_word  word_backlog [$];
    t_out_word cmd_expected [$];
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_arm = 0;
    int        hold_left = 0;
    int        cycles = 0;

    function automatic void queue_word(t_in_word w);
        word_backlog.insert(word_backlog.size(), w);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function automatic t_out_word flock_command();
        longint coh [3], sep [3], ali [3], mig [3], lead [3], res [3], df [3];
        longint d, dif, v;
        longint unsigned sq, nrm;
        longint unsigned m [3];
        bit near, fits;
        int s;
        t_out_word o;
        for (int k = 0; k < 3; k++) begin
            coh[k] = 0; sep[k] = 0; ali[k] = 0; mig[k] = 0; lead[k] = 0;
        end
        if (nb_cnt > 0) begin
            for (int i = 0; i < nb_cnt; i++) begin
                if (nb_id[i] != self_id) begin
                    near = 1;
                    for (int k = 0; k < 3; k++) begin
                        coh[k] += longint'(nb_pos[i][k]);
                        ali[k] += longint'(nb_vel[i][k]);
                        df[k] = longint'(own_pos[k]) - longint'(nb_pos[i][k]);
                        if (magn(df[k]) >= longint'(unsigned'(vis_rng))) near = 0;
                    end
                    if (near) begin
                        sq = 0;
                        for (int k = 0; k < 3; k++) sq += magn(df[k]) * magn(df[k]);
                        d = longint'(isqrt(sq));
                        if (d < vis_rng) begin
                            if (d < longint'(SEP_MIN_DIST)) d = longint'(SEP_SUB_DIST);
                            dif = vis_rng - d;
                            for (int k = 0; k < 3; k++) sep[k] += df[k] * dif / d;
                        end
                    end
                end
                if (nb_id[i] == 8'd0)
                    for (int k = 0; k < 3; k++) lead[k] = longint'(nb_pos[i][k]);
            end
            for (int k = 0; k < 3; k++) begin
                coh[k] = coh[k] / longint'(nb_cnt) - longint'(own_pos[k]);
                ali[k] = ali[k] / longint'(nb_cnt);
                mig[k] = longint'(frm_off[k]) - longint'(own_pos[k])
                       + (self_id != 8'd0 ? lead[k] : longint'(tgt_pos[k]));
            end
        end
        for (int k = 0; k < 3; k++) begin
            v = g_coh * coh[k] + g_sep * sep[k] + g_ali * ali[k] + g_mig * mig[k];
            res[k] = v >= 0 ? v / 256 : -((-v + 255) / 256);
        end
        s = 0;
        fits = 0;
        while (!fits) begin
            fits = 1;
            for (int k = 0; k < 3; k++)
                if ((magn(res[k]) >> s) >= 64'h8000_0000) fits = 0;
            if (!fits) s++;
        end
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = magn(res[k]) >> s;
            sq += m[k] * m[k];
        end
        nrm = isqrt(sq);
        if (s > 0 || nrm >= longint'(unsigned'(spd_lim))) begin
            for (int k = 0; k < 3; k++) begin
                v = nrm == 0 ? 0 : longint'(m[k] * longint'(unsigned'(spd_lim)) / nrm);
                res[k] = res[k] < 0 ? -v : v;
            end
        end
        o.cmd_x = res[0][31:0];
        o.cmd_y = res[1][31:0];
        o.cmd_z = res[2][31:0];
        o.cmd_enabled = ctl_en;
        return o;
    endfunction

    function automatic void apply_word(t_in_word w);
        logic signed [31:0] p [3], vl [3];
        int i;
        p = '{w.pos_x, w.pos_y, w.pos_z};
        vl = '{w.vel_x, w.vel_y, w.vel_z};
        case (w.func)
            F_OWN_POS: own_pos = p;
            F_TARGET:  tgt_pos = p;
            F_OFFSET:  frm_off = p;
            F_ENABLE:  ctl_en = w.enable_value;
            F_TICK:    cmd_expected.insert(cmd_expected.size(), flock_command());
            F_NEIGHBOR: begin
                if (w.uav_id != self_id) begin
                    i = 0;
                    while (i < nb_cnt && nb_id[i] != w.uav_id) i++;
                    if (i == nb_cnt && nb_cnt < NB_MAX) begin
                        nb_id[i] = w.uav_id;
                        nb_cnt++;
                    end
                    if (i < nb_cnt) begin
                        nb_pos[i] = p;
                        nb_vel[i] = vl;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) apply_word(i_in_word);
            if (word_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_in_word <= word_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_arm) begin
            hold_arm = 0;
            hold_left = 3000;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cmd_expected.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                errors++;
            end else begin
                e = cmd_expected.pop_front();
                if (o_out_word.cmd_x !== e.cmd_x) begin
                    $display("%0t: cmd_x exp %h got %h", $time, e.cmd_x, o_out_word.cmd_x);
                    errors++;
                end
                if (o_out_word.cmd_y !== e.cmd_y) begin
                    $display("%0t: cmd_y exp %h got %h", $time, e.cmd_y, o_out_word.cmd_y);
                    errors++;
                end
                if (o_out_word.cmd_z !== e.cmd_z) begin
                    $display("%0t: cmd_z exp %h got %h", $time, e.cmd_z, o_out_word.cmd_z);
                    errors++;
                end
                if (o_out_word.cmd_enabled !== e.cmd_enabled) begin
                    $display("%0t: cmd_enabled exp %b got %b", $time, e.cmd_enabled,
                             o_out_word.cmd_enabled);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("boids_flocking_velocity_tb: FAIL");
            $finish;
        end
    end

    task automatic reg_write(t_reg r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            R_GAIN_COH: g_coh = longint'($signed(v[15:0]));
            R_GAIN_SEP: g_sep = longint'($signed(v[15:0]));
            R_GAIN_ALI: g_ali = longint'($signed(v[15:0]));
            R_GAIN_MIG: g_mig = longint'($signed(v[15:0]));
            R_SPEED:    spd_lim = longint'(v[30:0]);
            R_VISION:   vis_rng = longint'(v[30:0]);
            R_OWN_ID:   self_id = v[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (word_backlog.size() > 0 || i_in_valid || cmd_expected.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_in_word mk(logic [2:0] f, logic [7:0] id, logic [31:0] px,
                                    logic [31:0] py, logic [31:0] pz, logic [31:0] vx,
                                    logic [31:0] vy, logic [31:0] vz, logic en);
        t_in_word w;
        w.func = f; w.uav_id = id;
        w.pos_x = px; w.pos_y = py; w.pos_z = pz;
        w.vel_x = vx; w.vel_y = vy; w.vel_z = vz;
        w.enable_value = en;
        return w;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(9))
            6, 7:    return $urandom;
            8:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            9:       return 32'd0;
            default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
        endcase
    endfunction

    function automatic t_in_word rnd_word();
        int r;
        logic [2:0] f;
        logic [7:0] id;
        r = $urandom_range(99);
        if (r < 40)      f = F_NEIGHBOR;
        else if (r < 55) f = F_TICK;
        else if (r < 65) f = F_OWN_POS;
        else if (r < 73) f = F_TARGET;
        else if (r < 81) f = F_OFFSET;
        else if (r < 97) f = F_ENABLE;
        else             f = 3'($urandom_range(6, 7));
        id = $urandom_range(3) != 0 ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 255));
        return mk(f, id, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                  1'($urandom_range(1)));
    endfunction

    function automatic logic [31:0] rnd_gain();
        case ($urandom_range(5))
            0:       return 32'hffff_8000;
            1:       return 32'h0000_7fff;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 768)) - 32'd256;
        endcase
    endfunction

    initial begin
        t_in_word w;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_word(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_word(mk(F_ENABLE, 0, 0, 0, 0, 0, 0, 0, 1));
        queue_word(mk(F_OWN_POS, 0, 32'h10000, 32'h20000, 32'hffff0000,
                      0, 0, 0, 0));
        queue_word(mk(F_NEIGHBOR, 0, 5, 6, 7, 8, 9, 10, 0));
        queue_word(mk(F_NEIGHBOR, 1, 32'h18000, 32'h20000, 32'hffff0000,
                      32'h100, 32'hffff_ff00, 32'h2000, 0));
        queue_word(mk(F_NEIGHBOR, 2, 32'h10000, 32'h20000, 32'hffff0000,
                      0, 0, 0, 0));
        queue_word(mk(F_TARGET, 0, 32'h50000, 32'hfffb0000, 32'h30000,
                      0, 0, 0, 0));
        queue_word(mk(F_OFFSET, 0, 32'h8000, 32'h8000, 32'hffff8000,
                      0, 0, 0, 0));
        queue_word(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_word(mk(F_NEIGHBOR, 1, 32'h10100, 32'h20000, 32'hffff0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1));
        queue_word(mk(F_NEIGHBOR, 255, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 1));
        queue_word(mk(3'd6, 9, 1, 2, 3, 4, 5, 6, 1));
        queue_word(mk(3'd7, 9, 1, 2, 3, 4, 5, 6, 1));
        queue_word(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_word(mk(F_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_word(mk(F_OWN_POS, 0, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 0, 0, 0, 0));
        queue_word(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        for (int p = 0; p < 8; p++) begin
            reg_write(R_GAIN_COH, rnd_gain());
            reg_write(R_GAIN_SEP, rnd_gain());
            reg_write(R_GAIN_ALI, rnd_gain());
            reg_write(R_GAIN_MIG, rnd_gain());
            reg_write(R_SPEED, p == 1 ? 32'd1 : p == 3 ? 32'h7fff_ffff
                               : 32'($urandom_range(1, 1 << 20)));
            reg_write(R_VISION, p == 1 ? 32'd0 : p == 3 ? 32'h7fff_ffff
                                : 32'($urandom_range(0, 1 << 21)));
            case ($urandom_range(3))
                0:       reg_write(R_OWN_ID, 32'd0);
                1:       reg_write(R_OWN_ID, 32'd255);
                default: reg_write(R_OWN_ID, 32'($urandom_range(1, 20)));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            if (p == 4) begin
                idle_pct = 0;
                stall_pct = 0;
                hold_arm = 1;
            end
            for (int c = 0; c < 2; c++) begin
                n = 0;
                while (n < 38) begin
                    w = rnd_word();
                    if (w.func <= F_TICK) n++;
                    queue_word(w);
                end
                drain();
            end
        end

        if (errors == 0) begin
            $display("boids_flocking_velocity_tb: PASS");
        end else begin
            $display("boids_flocking_velocity_tb: FAIL");
        end
        $finish;
    end

endmodule
